// File: hdl/cfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the contiguous frame allocator: field widths,
// status codes, sequencer states and configuration register indexes.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int ADDR_W         = 32;
    localparam int AOUT_W         = 31;
    localparam int CNT_W          = 11;
    localparam int STAT_W         = 3;
    localparam int CFG_IDX_W      = 1;

    localparam int WORD_BITS      = 32;
    localparam int WB_SHIFT       = $clog2(WORD_BITS);

    localparam int FRAME_BYTES    = 4096;
    localparam int FRAME_SHIFT    = $clog2(FRAME_BYTES);

    localparam int MAX_FRAMES_DEF = 1024;

    localparam logic [ADDR_W-1:0] BASE_RESET   = 32'h8000_0000;
    localparam logic [CNT_W-1:0]  FCOUNT_RESET = 11'd1024;
    localparam logic [ADDR_W-1:0] KERNEL_BIT   = 32'h8000_0000;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOMEM    = 3'd1,
        ST_BADADDR  = 3'd2,
        ST_DOUBLE   = 3'd3,
        ST_BADCOUNT = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE   = 1'b0,
        REG_FCOUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FCHECK,
        S_SCAN,
        S_PRE,
        S_PASS,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_SET,
        M_CHECK,
        M_RELEASE
    } t_mode;

endpackage
`default_nettype wire

// File: hdl/cfa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_req_if
// Request channel: allocate or free a run of frames.
// ----------------------------------------------------------------------------
interface cfa_req_if import cfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] address_in;

    modport source (output valid, output action, output count, output address_in,
                    input ready);
    modport sink   (input valid, input action, input count, input address_in,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/cfa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_rsp_if
// Response channel: status and first frame address of one request.
// ----------------------------------------------------------------------------
interface cfa_rsp_if import cfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [AOUT_W-1:0] address_out;

    modport source (output valid, output status, output address_out, input ready);
    modport sink   (input valid, input status, input address_out, output ready);
endinterface
`default_nettype wire

// File: hdl/contiguous_frame_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_frame_allocator
// First-fit allocator of contiguous physical frames over a one-bit-per-frame
// occupancy map held in a word-wide memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request beat (action, count, address_in); o_rsp returns
//   one beat (status, address_out) for it. base_address (index 0) and
//   frame_count (index 1) are to be written through i_cfg_* only while idle;
//   the block itself does not enforce it. The map is kept as 32-bit words,
//   one word handled per cycle. An allocate decodes, scans words up to the
//   first fitting run, reads the run's first word, marks each word of the
//   run and posts. A free decodes, range-checks, reads and checks each word
//   of the run, reads and clears each word of it, then posts. Invalid counts
//   and oversized allocates post straight after decode, a bad free address
//   after the range check.
//   i_req is ready only in idle, from the cycle after a result is posted.
//   After reset the map is swept to all free, one word per cycle, with
//   i_req not ready.
//   A stalled receiver holds the response register; the next request is
//   accepted meanwhile and waits to post until the register frees.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator import cfa_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    cfa_req_if.sink                   i_req,
    cfa_rsp_if.source                 o_rsp
);

    localparam int IW    = $clog2(MAX_FRAMES + 1);
    localparam int FW    = (IW > CNT_W ? IW : CNT_W) + 1;
    localparam int WCW   = FW - WB_SHIFT;
    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    // control
    t_state             r_state, n_state;
    t_mode              r_mode,  n_mode;
    logic [WCW-1:0]     r_word,  n_word;
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_base,  n_base;
    logic [CNT_W-1:0]   r_fcount, n_fcount;

    // payload
    logic               r_action, n_action;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_addr,  n_addr;
    logic [FW-1:0]      r_n,     n_n;
    logic [ADDR_W-1:0]  r_off,   n_off;
    logic [FW-1:0]      r_carry, n_carry;
    logic [FW-1:0]      r_lo,    n_lo;
    logic [FW-1:0]      r_hi,    n_hi;
    t_status            r_res_status, n_res_status;
    logic [AOUT_W-1:0]  r_res_addr,   n_res_addr;
    t_status            r_out_status, n_out_status;
    logic [AOUT_W-1:0]  r_out_addr,   n_out_addr;

    // map memory
    logic [WORD_BITS-1:0] r_map [WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [WAW-1:0]       mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // word datapath
    logic [WCW-1:0]       lo_word, hi_word, last_word;
    logic [FW-1:0]        n_minus1;
    logic [WB_SHIFT-1:0]  lo_bit, hi_bit;
    logic [WORD_BITS-1:0] run_mask;
    logic [FW-1:0]        rem;
    logic [WORD_BITS-1:0] vmask, free_v, used_v, pre_free, win, carry_v, cand;
    logic [FW-1:0]        i0;
    logic                 hit;
    logic [WB_SHIFT-1:0]  hit_pos, hz;
    logic [FW-1:0]        carry_next;
    logic [FW-1:0]        hit_hi;
    logic [ADDR_W-1:0]    idx32, end32, alloc_addr;

    assign lo_word   = r_lo[FW-1:WB_SHIFT];
    assign hi_word   = r_hi[FW-1:WB_SHIFT];
    assign n_minus1  = r_n - FW'(1);
    assign last_word = n_minus1[FW-1:WB_SHIFT];

    // mask of the run's frames inside the current word
    always_comb begin
        lo_bit   = (r_word == lo_word) ? r_lo[WB_SHIFT-1:0] : '0;
        hi_bit   = (r_word == hi_word) ? r_hi[WB_SHIFT-1:0] : WB_SHIFT'(WORD_BITS - 1);
        run_mask = (ONES << lo_bit) & (ONES >> (WB_SHIFT'(WORD_BITS - 1) - hi_bit));
    end

    // one scan step: find the lowest end of a free run of r_count frames
    always_comb begin
        rem    = r_n - {r_word, WB_SHIFT'(0)};
        vmask  = (rem >= FW'(WORD_BITS)) ? ONES
                                         : ((WORD_BITS'(1) << rem[WB_SHIFT-1:0]) - WORD_BITS'(1));
        // frames past the live count look used
        free_v = ~r_rdata & vmask;
        used_v = ~free_v;

        // free prefix from bit 0 up to the lowest used frame
        pre_free = (used_v == '0) ? ONES : ((used_v & (~used_v + WORD_BITS'(1))) - WORD_BITS'(1));

        // run continued from the words below
        i0      = FW'(r_count) - r_carry - FW'(1);
        carry_v = (i0 < FW'(WORD_BITS)) ? ((WORD_BITS'(1) << i0[WB_SHIFT-1:0]) & pre_free) : '0;

        // runs lying wholly inside this word
        win = (r_count > CNT_W'(WORD_BITS)) ? '0 : free_v;
        for (int j = 1; j < WORD_BITS; j++) begin
            if (CNT_W'(j) < r_count) begin
                win = win & (free_v << j);
            end
        end

        cand    = win | carry_v;
        hit     = |cand;
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                hit_pos = WB_SHIFT'(j);
            end
        end
        hit_hi = {r_word, hit_pos};

        hz = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (!free_v[j]) begin
                hz = WB_SHIFT'(j);
            end
        end
        carry_next = (free_v == ONES) ? (r_carry + FW'(WORD_BITS))
                                      : FW'(WB_SHIFT'(WORD_BITS - 1) - hz);
    end

    assign idx32      = r_off >> FRAME_SHIFT;
    assign end32      = idx32 + ADDR_W'(r_count);
    assign alloc_addr = r_base + (ADDR_W'(r_lo) << FRAME_SHIFT);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_word       = r_word;
        n_base       = r_base;
        n_fcount     = r_fcount;
        n_action     = r_action;
        n_count      = r_count;
        n_addr       = r_addr;
        n_n          = r_n;
        n_off        = r_off;
        n_carry      = r_carry;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_valid  = r_out_valid & ~o_rsp.ready;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        mem_raddr    = WAW'(r_word + WCW'(1));

        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_BASE:   n_base   = i_cfg_data;
                REG_FCOUNT: n_fcount = i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_word    = r_word + WCW'(1);
                if (r_word == WCW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action = i_req.action;
                    n_count  = i_req.count;
                    n_addr   = i_req.address_in;
                    n_n      = (FW'(r_fcount) < FW'(MAX_FRAMES)) ? FW'(r_fcount)
                                                                 : FW'(MAX_FRAMES);
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                // prefetch word 0 for the scan
                mem_raddr = '0;
                n_off     = (r_addr | KERNEL_BIT) - r_base;
                n_word    = '0;
                n_carry   = '0;
                n_res_addr = '0;
                if (r_count == '0) begin
                    n_res_status = ST_BADCOUNT;
                    n_state      = S_DONE;
                end else if (r_action) begin
                    n_state = S_FCHECK;
                end else if (FW'(r_count) > r_n) begin
                    n_res_status = ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FCHECK: begin
                if (r_off[ADDR_W-1] || (r_off[FRAME_SHIFT-1:0] != '0)
                        || (end32 > ADDR_W'(r_n))) begin
                    n_res_status = ST_BADADDR;
                    n_state      = S_DONE;
                end else begin
                    n_lo    = idx32[FW-1:0];
                    n_hi    = FW'(end32 - ADDR_W'(1));
                    n_word  = idx32[FW-1:WB_SHIFT];
                    n_mode  = M_CHECK;
                    n_state = S_PRE;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_hi    = hit_hi;
                    n_lo    = hit_hi - FW'(r_count) + FW'(1);
                    n_word  = n_lo[FW-1:WB_SHIFT];
                    n_mode  = M_SET;
                    n_state = S_PRE;
                end else if (r_word == last_word) begin
                    n_res_status = ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    n_word  = r_word + WCW'(1);
                    n_carry = carry_next;
                end
            end
            S_PRE: begin
                mem_raddr = r_word[WAW-1:0];
                n_state   = S_PASS;
            end
            S_PASS: begin
                n_word = r_word + WCW'(1);
                case (r_mode)
                    M_SET: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rdata | run_mask;
                        if (r_word == hi_word) begin
                            n_res_status = ST_OK;
                            n_res_addr   = alloc_addr[AOUT_W-1:0];
                            n_state      = S_DONE;
                        end
                    end
                    M_CHECK: begin
                        if ((r_rdata & run_mask) != run_mask) begin
                            n_res_status = ST_DOUBLE;
                            n_state      = S_DONE;
                        end else if (r_word == hi_word) begin
                            // whole run is allocated: go back and release it
                            n_word  = lo_word;
                            n_mode  = M_RELEASE;
                            n_state = S_PRE;
                        end
                    end
                    default: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rdata & ~run_mask;
                        if (r_word == hi_word) begin
                            n_res_status = ST_OK;
                            n_state      = S_DONE;
                        end
                    end
                endcase
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_mode      <= M_SET;
            r_word      <= '0;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
            r_fcount    <= FCOUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
            r_base      <= n_base;
            r_fcount    <= n_fcount;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_count      <= n_count;
        r_addr       <= n_addr;
        r_n          <= n_n;
        r_off        <= n_off;
        r_carry      <= n_carry;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_word[WAW-1:0]] <= mem_wdata;
        end
        r_rdata <= r_map[mem_raddr];
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.address_out = r_out_addr;

endmodule
`default_nettype wire

// File: hdl/cfa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cfa_checker import cfa_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic [STAT_W-1:0] i_rsp_status,
    input wire logic [AOUT_W-1:0] i_rsp_address_out
);

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_address_out))
        else $error("response beat changed while stalled");

    // a request keeps the block busy: ready drops after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request side ready right after an accept");

    // only a successful allocate returns an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |-> (i_rsp_address_out == '0))
        else $error("address returned with a failing status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status <= ST_BADCOUNT))
        else $error("undefined status code");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_address_out (o_rsp.address_out)
);
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contiguous frame allocator. It keeps its own
// shadow of the occupancy map and base/count registers, predicts the status
// and address of every request beat, and compares responses in order. Runs a
// directed sweep of corner cases, then random traffic under several map
// configurations, with random idling and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
    import cfa_pkg::*;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_FREE    = 1'b1;
    localparam int   HOLD_CYCLES = 300;
    localparam int   CYCLE_LIMIT = 300000;
    localparam int   SETTLE      = 60;
    localparam int   MAX_REPORTS = 10;

    typedef struct packed {
        t_status           status;
        logic [AOUT_W-1:0] address;
    } t_frame_rsp;

    // Shadow of the occupancy map plus the queue of responses still owed.
    class frame_map_scoreboard;
        bit                frame_used [MAX_FRAMES_DEF];
        logic [ADDR_W-1:0] base_addr;
        logic [CNT_W-1:0]  frame_cnt;
        t_frame_rsp        rsp_q [$];
        int                n_errors;
        int                n_alloc;
        int                n_free;
        int                status_seen [8];

        function new();
            base_addr = BASE_RESET;
            frame_cnt = FCOUNT_RESET;
            n_errors  = 0;
            n_alloc   = 0;
            n_free    = 0;
            foreach (frame_used[i]) frame_used[i] = 1'b0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void configure(input t_cfg_reg idx, input logic [ADDR_W-1:0] data);
            case (idx)
                REG_BASE:   base_addr = data;
                REG_FCOUNT: frame_cnt = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned live_frames();
            return (frame_cnt < MAX_FRAMES_DEF) ? frame_cnt : MAX_FRAMES_DEF;
        endfunction

        function void note_request(input logic act, input logic [CNT_W-1:0] count,
                                   input logic [ADDR_W-1:0] addr);
            int unsigned       n;
            int unsigned       run;
            int unsigned       first;
            int unsigned       idx;
            bit                hit;
            bit                all_used;
            logic [ADDR_W-1:0] offset;
            logic [ADDR_W-1:0] grant;
            t_frame_rsp        want;
            n            = live_frames();
            want.status  = ST_OK;
            want.address = '0;
            if (act == ACT_FREE) n_free++;
            else n_alloc++;
            if (count == '0) begin
                want.status = ST_BADCOUNT;
            end else if (act == ACT_ALLOC) begin
                run   = 0;
                first = 0;
                hit   = 1'b0;
                // first fit: lowest run of free frames long enough
                for (int i = 0; i < int'(n) && !hit; i++) begin
                    if (frame_used[i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == count) begin
                            first = i + 1 - count;
                            hit   = 1'b1;
                        end
                    end
                end
                if (!hit) begin
                    want.status = ST_NOMEM;
                end else begin
                    for (int i = 0; i < count; i++) frame_used[first + i] = 1'b1;
                    grant        = base_addr + first * FRAME_BYTES;
                    want.address = grant[AOUT_W-1:0];
                end
            end else begin
                offset = (addr | KERNEL_BIT) - base_addr;
                if (offset[ADDR_W-1] || offset[FRAME_SHIFT-1:0] != '0) begin
                    want.status = ST_BADADDR;
                end else begin
                    idx = offset >> FRAME_SHIFT;
                    if (idx > n || count > n - idx) begin
                        want.status = ST_BADADDR;
                    end else begin
                        all_used = 1'b1;
                        for (int i = 0; i < count; i++)
                            if (!frame_used[idx + i]) all_used = 1'b0;
                        if (!all_used) want.status = ST_DOUBLE;
                        else for (int i = 0; i < count; i++) frame_used[idx + i] = 1'b0;
                    end
                end
            end
            status_seen[want.status]++;
            rsp_q.push_back(want);
        endfunction

        function void check_result(input logic [STAT_W-1:0] status,
                                   input logic [AOUT_W-1:0] address);
            t_frame_rsp want;
            if (rsp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("ERROR: response beat with none owed: status %0d address 0x%08h",
                             status, address);
            end else begin
                want = rsp_q.pop_front();
                if (status !== want.status || address !== want.address) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("ERROR: expected status %0d address 0x%08h, got %0d 0x%08h",
                                 want.status, want.address, status, address);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0]    i_cfg_data;

    cfa_req_if req_if ();
    cfa_rsp_if rsp_if ();

    frame_map_scoreboard sb;
    int                  snd_idle_pct;
    int                  rcv_idle_pct;
    bit                  hold_rsp;
    int                  cycle_cnt;
    int                  n_fail;

    contiguous_frame_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.status, rsp_if.address_out);
    end

    // Response side: random backpressure, or one long hold-off on request.
    initial begin
        int hold_left;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
                for (hold_left = HOLD_CYCLES - 1; hold_left > 0; hold_left--)
                    @(negedge i_clk);
                hold_rsp = 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic logic [ADDR_W-1:0] frame_addr(input int unsigned idx);
        return sb.base_addr + idx * FRAME_BYTES;
    endfunction

    task automatic send_request(input logic act, input logic [CNT_W-1:0] cnt,
                                input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.count      <= cnt;
        req_if.address_in <= addr;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(act, cnt, addr);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every owed response beat is back.
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (sb.rsp_q.size() != 0);
    endtask

    task automatic set_config(input logic [ADDR_W-1:0] base, input logic [CNT_W-1:0] fcount);
        logic [ADDR_W-1:0] fc_word;
        fc_word              = $urandom;
        fc_word[CNT_W-1:0]   = fcount;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_BASE;
        i_cfg_data <= base;
        @(negedge i_clk);
        i_cfg_idx  <= REG_FCOUNT;
        i_cfg_data <= fc_word;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.configure(REG_BASE, base);
        sb.configure(REG_FCOUNT, fc_word);
    endtask

    // Mostly well-formed traffic: allocs while the map has room, frees of
    // frames that are really used, plus some noise and zero counts.
    function automatic void pick_request(output logic act, output logic [CNT_W-1:0] cnt,
                                         output logic [ADDR_W-1:0] addr);
        int unsigned n;
        int unsigned used;
        int unsigned roll;
        int unsigned idx;
        int unsigned k;
        int unsigned run_len;
        bit          found;
        n    = sb.live_frames();
        used = 0;
        for (int i = 0; i < int'(n); i++) used += sb.frame_used[i];
        act  = ACT_ALLOC;
        cnt  = '0;
        addr = $urandom;
        roll = $urandom_range(99);
        if (roll < 4) begin
            act = 1'($urandom_range(1));
            cnt = CNT_W'($urandom_range(2047));
        end else if (roll < 7) begin
            act = 1'($urandom_range(1));
        end else if ($urandom_range(99) >= ((n == 0) ? 50 : used * 100 / n + 10)) begin
            roll = $urandom_range(99);
            if (roll < 70) cnt = CNT_W'($urandom_range(8, 1));
            else if (roll < 90) cnt = CNT_W'($urandom_range(48, 1));
            else if (roll < 98) cnt = CNT_W'($urandom_range((n > 0) ? n : 1, 1));
            else cnt = CNT_W'($urandom_range(2047, n + 1));
        end else begin
            act   = ACT_FREE;
            idx   = (n > 0) ? $urandom_range(n - 1) : $urandom_range(7);
            found = 1'b0;
            for (int i = 0; i < int'(n) && !found; i++) begin
                k = (idx + i) % n;
                if (sb.frame_used[k]) begin
                    idx   = k;
                    found = 1'b1;
                end
            end
            run_len = 0;
            while (idx + run_len < n && sb.frame_used[idx + run_len]) run_len++;
            roll = $urandom_range(99);
            if (roll < 80) cnt = CNT_W'($urandom_range((run_len > 0) ? run_len : 1, 1));
            else if (roll < 92) cnt = CNT_W'(run_len + $urandom_range(3, 1));
            else cnt = CNT_W'($urandom_range(64, 1));
            addr = frame_addr(idx);
            if ($urandom_range(99) < 6) addr += $urandom_range(FRAME_BYTES - 1, 1);
            // bit 31 is ORed back in by the block
            if ($urandom_range(1)) addr[ADDR_W-1] = 1'b0;
        end
    endfunction

    task automatic run_random(input int n_items);
        logic              act;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] addr;
        repeat (n_items) begin
            pick_request(act, cnt, addr);
            send_request(act, cnt, addr);
        end
    endtask

    initial begin
        sb                = new();
        cycle_cnt         = 0;
        hold_rsp          = 1'b0;
        snd_idle_pct      = 21;
        rcv_idle_pct      = 48;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_BASE;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_ALLOC;
        req_if.count      = '0;
        req_if.address_in = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners at the reset configuration
        send_request(ACT_ALLOC, 11'd0, 32'h0);
        send_request(ACT_FREE,  11'd0, frame_addr(0));
        send_request(ACT_ALLOC, 11'd1, 32'h0);
        send_request(ACT_ALLOC, 11'd1024, 32'h0);
        send_request(ACT_ALLOC, 11'd2047, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 11'd3, 32'h0);
        send_request(ACT_FREE,  11'd1, 32'h0000_0000);
        send_request(ACT_FREE,  11'd1, 32'h8000_0000);
        send_request(ACT_FREE,  11'd1, 32'h8000_1800);
        send_request(ACT_FREE,  11'd1, 32'hFFFF_FFFF);
        send_request(ACT_FREE,  11'd8, frame_addr(1020));
        send_request(ACT_FREE,  11'd4, frame_addr(1));
        send_request(ACT_FREE,  11'd3, frame_addr(1));
        send_request(ACT_ALLOC, 11'd1024, 32'h0);
        send_request(ACT_ALLOC, 11'd1, 32'h0);
        send_request(ACT_FREE,  11'd2047, frame_addr(0));
        send_request(ACT_FREE,  11'd1024, 32'h7FFF_F000);
        send_request(ACT_FREE,  11'd1024, frame_addr(0));
        send_request(ACT_ALLOC, 11'd1024, 32'h0);
        drain();

        // shrink the map under a full occupancy; upper frames keep their bits
        set_config(32'h9000_0000, 11'd8);
        send_request(ACT_FREE,  11'd1, 32'h0000_1000);
        send_request(ACT_FREE,  11'd8, frame_addr(0));
        send_request(ACT_ALLOC, 11'd9, 32'h0);
        send_request(ACT_ALLOC, 11'd8, 32'h0);
        send_request(ACT_FREE,  11'd1, frame_addr(8));
        drain();
        set_config(BASE_RESET, FCOUNT_RESET);
        send_request(ACT_FREE,  11'd1024, frame_addr(0));

        run_random(170);
        drain();
        snd_idle_pct = 48;
        rcv_idle_pct = 21;
        set_config(32'hC000_0800, 11'd40);
        run_random(170);
        drain();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_config(32'hFFFF_FFFF, 11'd2047);
        run_random(60);
        drain();
        set_config(32'h0000_0000, 11'd0);
        run_random(20);
        drain();
        set_config(BASE_RESET, FCOUNT_RESET);
        run_random(50);
        // stall the receiver and keep offering beats until the input backs up
        hold_rsp = 1'b1;
        run_random(10);
        drain();
        run_random(70);
        drain();
        repeat (SETTLE) @(negedge i_clk);

        n_fail = sb.n_errors + sb.rsp_q.size();
        $display("Ran %0d requests (%0d allocate, %0d free) over five map configurations",
                 sb.n_alloc + sb.n_free, sb.n_alloc, sb.n_free);
        $display("Status mix: ok %0d, no memory %0d, bad address %0d, double free %0d, %s %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NOMEM], sb.status_seen[ST_BADADDR],
                 sb.status_seen[ST_DOUBLE], "bad count", sb.status_seen[ST_BADCOUNT]);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Mismatches: %0d", n_fail);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
